[src/ec_prime_point_add_unit_macros.svh]
// Assertion macros shared by the point adder.
`ifndef EC_PRIME_POINT_ADD_UNIT_MACROS_SVH
`define EC_PRIME_POINT_ADD_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define EPA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define EPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define EPA_ASSERT_IMP(label, clk, rst, ante, cons)
`define EPA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[src/epa_pkg.sv]
package epa_pkg;

  localparam int W = 32;
  localparam int CW = $clog2(W);

  localparam logic CFG_FIELD_PRIME = 1'b0;
  localparam logic CFG_CURVE_A = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_RX1, S_RY1, S_RX2, S_RY2, S_RA, S_CHECK, S_SQ, S_DBL1, S_DBL2, S_DBL3,
    S_EUC, S_DIV, S_EUPD, S_EINV, S_MSL, S_MSQ, S_X3A, S_X3B, S_D, S_MY, S_Y3, S_FIN
  } state_t;

  function automatic logic [W-1:0] add_mod(input logic [W-1:0] u, input logic [W-1:0] v,
                                           input logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, u} + {1'b0, v};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] sub_mod(input logic [W-1:0] u, input logic [W-1:0] v,
                                           input logic [W-1:0] m);
    logic [W-1:0] d;
    d = u - v;
    if (u < v) d = d + m;
    return d;
  endfunction

endpackage

[src/ec_prime_point_add_unit.sv]
// Affine point adder for y^2 = x^3 + a*x + b over a prime field.
// Configuration: cfg_we writes cfg_data into field_prime (index 0) or curve_a (index 1);
// write only while the unit is idle. Reset restores 9181 and 1488.
// Input stream: tdata carries both points, tuser their infinity flags. One transaction
// gives one result transaction: the sum point, its infinity flag and a flag that is set
// when the slope denominator has no inverse, when the field prime is below 3, or when
// two points with equal x are neither equal nor opposite. All products run through one
// bit-serial modular multiplier that takes one bit per cycle: the five input reductions,
// the quotient products of the inverse by Euclid's algorithm, one per remainder step,
// and the slope and coordinates, three more products, with one more for the square when
// a point is doubled. The special cases finish after the reductions; a field prime
// below 3 skips them.
// Items are taken one at a time. The finished result sits in an output register, so a
// new transaction is accepted while the receiver stalls; the next result then waits in
// the sequencer until the output register has been taken.
// Reset clears the sequencer and the output valid flag.
`include "ec_prime_point_add_unit_macros.svh"
module ec_prime_point_add_unit
  import epa_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [W-1:0]   cfg_data,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  // first_x, first_y, second_x, second_y
  input  logic [4*W-1:0] s_axis_tdata,
  // first_infinite, second_infinite
  input  logic [1:0]     s_axis_tuser,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  // sum_x, sum_y
  output logic [2*W-1:0] m_axis_tdata,
  // sum_infinite, bad_operand
  output logic [1:0]     m_axis_tuser
);

  localparam logic [CW-1:0] CMAX = CW'(W - 1);

  state_t state, state_next;

  logic [W-1:0] field_prime, curve_a;
  logic [W-1:0] pm, x1, y1, x2, y2, ca, num, w, x3, mreg;
  logic [W-1:0] r0, r1, t0, t1, dv, rem;
  logic [W-1:0] mu, mv, acc;
  logic [CW-1:0] cnt;
  logic inf1, inf2;
  logic [W-1:0] res_x, res_y;
  logic res_inf, res_bad;
  logic [W-1:0] out_x, out_y;
  logic out_inf, out_bad, out_valid;

  logic running, last, mbit, qbit, load_out;
  logic [W:0] trial;
  logic [W-1:0] mstep, negy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_prime <= W'(9181);
      curve_a <= W'(1488);
    end else if (cfg_we) begin
      if (cfg_index == CFG_FIELD_PRIME) field_prime <= cfg_data;
      else curve_a <= cfg_data;
    end
  end

  assign running = (state == S_RX1) || (state == S_RY1) || (state == S_RX2) ||
                   (state == S_RY2) || (state == S_RA) || (state == S_SQ) ||
                   (state == S_DIV) || (state == S_MSL) || (state == S_MSQ) ||
                   (state == S_MY);
  assign last = (cnt == '0);
  assign trial = {rem, dv[W-1]};
  assign qbit = (trial >= {1'b0, r1});
  assign mbit = (state == S_DIV) ? qbit : mv[W-1];
  assign mstep = mbit ? add_mod(add_mod(acc, acc, pm), mu, pm) : add_mod(acc, acc, pm);
  assign negy2 = (y2 == '0) ? '0 : pm - y2;
  assign load_out = (state == S_FIN) && (!out_valid || m_axis_tready);
  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) state_next = (field_prime < W'(3)) ? S_FIN : S_RX1;
      end
      S_RX1: if (last) state_next = S_RY1;
      S_RY1: if (last) state_next = S_RX2;
      S_RX2: if (last) state_next = S_RY2;
      S_RY2: if (last) state_next = S_RA;
      S_RA: if (last) state_next = S_CHECK;
      S_CHECK: begin
        if (inf1 || inf2) state_next = S_FIN;
        else if (x1 == x2) state_next = (y1 == negy2 || y1 != y2) ? S_FIN : S_SQ;
        else state_next = S_EUC;
      end
      S_SQ: if (last) state_next = S_DBL1;
      S_DBL1: state_next = S_DBL2;
      S_DBL2: state_next = S_DBL3;
      S_DBL3: state_next = S_EUC;
      S_EUC: state_next = (r1 == '0) ? S_EINV : S_DIV;
      S_DIV: if (last) state_next = S_EUPD;
      S_EUPD: state_next = S_EUC;
      S_EINV: state_next = (r0 != W'(1)) ? S_FIN : S_MSL;
      S_MSL: if (last) state_next = S_MSQ;
      S_MSQ: if (last) state_next = S_X3A;
      S_X3A: state_next = S_X3B;
      S_X3B: state_next = S_D;
      S_D: state_next = S_MY;
      S_MY: if (last) state_next = S_Y3;
      S_Y3: state_next = S_FIN;
      S_FIN: if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (running && !last) begin
      acc <= mstep;
      cnt <= cnt - CW'(1);
      mv <= {mv[W-2:0], 1'b0};
    end else begin
      acc <= '0;
      cnt <= CMAX;
    end
    if (state == S_DIV) begin
      dv <= {dv[W-2:0], 1'b0};
      rem <= qbit ? W'(trial - {1'b0, r1}) : trial[W-1:0];
    end
    case (state)
      S_IDLE: begin
        pm <= field_prime;
        ca <= curve_a;
        x1 <= s_axis_tdata[W-1:0];
        y1 <= s_axis_tdata[2*W-1:W];
        x2 <= s_axis_tdata[3*W-1:2*W];
        y2 <= s_axis_tdata[4*W-1:3*W];
        inf1 <= s_axis_tuser[0];
        inf2 <= s_axis_tuser[1];
        mu <= W'(1);
        mv <= s_axis_tdata[W-1:0];
        res_x <= '0;
        res_y <= '0;
        res_inf <= 1'b0;
        res_bad <= 1'b1;
      end
      S_RX1: if (last) begin x1 <= mstep; mv <= y1; end
      S_RY1: if (last) begin y1 <= mstep; mv <= x2; end
      S_RX2: if (last) begin x2 <= mstep; mv <= y2; end
      S_RY2: if (last) begin y2 <= mstep; mv <= ca; end
      S_RA: if (last) begin ca <= mstep; end
      S_CHECK: begin
        res_bad <= 1'b0;
        r0 <= pm;
        t0 <= '0;
        t1 <= W'(1);
        mu <= x1;
        mv <= x1;
        if (inf1 && inf2) begin
          res_inf <= 1'b1;
        end else if (inf1) begin
          res_x <= x2;
          res_y <= y2;
        end else if (inf2) begin
          res_x <= x1;
          res_y <= y1;
        end else if (x1 == x2) begin
          if (y1 == negy2) res_inf <= 1'b1;
          else if (y1 != y2) res_bad <= 1'b1;
          r1 <= add_mod(y1, y1, pm);
        end else begin
          num <= sub_mod(y2, y1, pm);
          r1 <= sub_mod(x2, x1, pm);
        end
      end
      S_SQ: if (last) w <= mstep;
      S_DBL1: num <= add_mod(w, w, pm);
      S_DBL2: num <= add_mod(num, w, pm);
      S_DBL3: num <= add_mod(num, ca, pm);
      S_EUC: begin
        dv <= r0;
        rem <= '0;
        mu <= t1;
      end
      S_DIV: if (last) w <= mstep;
      S_EUPD: begin
        r0 <= r1;
        r1 <= rem;
        t0 <= t1;
        t1 <= sub_mod(t0, w, pm);
      end
      S_EINV: begin
        mu <= num;
        mv <= t0;
        if (r0 != W'(1)) res_bad <= 1'b1;
      end
      S_MSL: if (last) begin mreg <= mstep; mu <= mstep; mv <= mstep; end
      S_MSQ: if (last) w <= mstep;
      S_X3A: w <= sub_mod(w, x1, pm);
      S_X3B: x3 <= sub_mod(w, x2, pm);
      S_D: begin
        mu <= mreg;
        mv <= sub_mod(x1, x3, pm);
      end
      S_MY: if (last) w <= mstep;
      S_Y3: begin
        res_x <= x3;
        res_y <= sub_mod(w, y1, pm);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (load_out) begin
      out_x <= res_x;
      out_y <= res_y;
      out_inf <= res_inf;
      out_bad <= res_bad;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {out_y, out_x};
  assign m_axis_tuser = {out_bad, out_inf};

  `EPA_ASSERT_IMP(a_div_nonzero, clk, rst, state == S_DIV, r1 != '0)
  `EPA_ASSERT_IMP(a_rem_below, clk, rst, state == S_DIV, rem < r1)
  `EPA_ASSERT_IMP(a_inf_zero, clk, rst, m_axis_tvalid && m_axis_tuser[0],
                  m_axis_tdata == '0 && !m_axis_tuser[1])
  `EPA_ASSERT_NEXT(a_load_valid, clk, rst, load_out, m_axis_tvalid)

endmodule

[sim/ec_prime_point_add_unit_test.sv]
`timescale 1ns / 100ps

module ec_prime_point_add_unit_test;
  import epa_pkg::*;

  typedef struct packed {
    logic [W-1:0] x;
    logic [W-1:0] y;
    logic         inf;
    logic         bad;
  } ec_sum_t;

  localparam int CYCLE_LIMIT = 3000000;

  logic           clk;
  logic           rst;
  logic           cfg_we;
  logic           cfg_index;
  logic [W-1:0]   cfg_data;
  logic           s_axis_tvalid;
  logic           s_axis_tready;
  logic [4*W-1:0] s_axis_tdata;
  logic [1:0]     s_axis_tuser;
  logic           m_axis_tvalid;
  logic           m_axis_tready;
  logic [2*W-1:0] m_axis_tdata;
  logic [1:0]     m_axis_tuser;

  logic [63:0] prime_q;
  logic [63:0] coeff_a_q;
  ec_sum_t     sums_due[$];
  int          fault_count;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_stall_pct;

  ec_prime_point_add_unit uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] fadd(logic [63:0] u, logic [63:0] v, logic [63:0] m);
    logic [64:0] s;
    s = {1'b0, u} + {1'b0, v};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[63:0];
  endfunction

  function automatic logic [63:0] fsub(logic [63:0] u, logic [63:0] v, logic [63:0] m);
    return (u >= v) ? (u - v) : (u + (m - v));
  endfunction

  function automatic logic [63:0] fmul(logic [63:0] u, logic [63:0] v, logic [63:0] m);
    logic [127:0] p;
    p = u * v;
    return 64'(p % m);
  endfunction

  function automatic ec_sum_t point_sum(logic [W-1:0] x1i, logic [W-1:0] y1i, logic inf1,
                                        logic [W-1:0] x2i, logic [W-1:0] y2i, logic inf2);
    ec_sum_t r;
    logic [63:0] p, x1, y1, x2, y2, a, num, den, r0, r1, r2, t0, t1, t2, q, sl, x3, y3;
    r = '0;
    p = prime_q;
    if (p < 64'd3) begin
      r.bad = 1'b1;
      return r;
    end
    x1 = x1i % p; y1 = y1i % p; x2 = x2i % p; y2 = y2i % p; a = coeff_a_q % p;
    if (inf1 && inf2) begin
      r.inf = 1'b1;
      return r;
    end
    if (inf1) begin
      r.x = W'(x2); r.y = W'(y2);
      return r;
    end
    if (inf2) begin
      r.x = W'(x1); r.y = W'(y1);
      return r;
    end
    if (x1 == x2) begin
      if (y1 == fsub(64'd0, y2, p)) begin
        r.inf = 1'b1;
        return r;
      end
      if (y1 != y2) begin
        r.bad = 1'b1;
        return r;
      end
      num = fadd(fmul(64'd3, fmul(x1, x1, p), p), a, p);
      den = fadd(y1, y1, p);
    end else begin
      num = fsub(y2, y1, p);
      den = fsub(x2, x1, p);
    end
    r0 = p; r1 = den; t0 = 64'd0; t1 = 64'd1;
    while (r1 != 64'd0) begin
      q = r0 / r1;
      r2 = r0 - q * r1;
      t2 = fsub(t0, fmul(q % p, t1, p), p);
      r0 = r1; r1 = r2; t0 = t1; t1 = t2;
    end
    if (r0 != 64'd1) begin
      r.bad = 1'b1;
      return r;
    end
    sl = fmul(num, t0, p);
    x3 = fsub(fsub(fmul(sl, sl, p), x1, p), x2, p);
    y3 = fsub(fmul(sl, fsub(x1, x3, p), p), y1, p);
    r.x = W'(x3); r.y = W'(y3);
    return r;
  endfunction

  task automatic send_points(logic [W-1:0] x1, logic [W-1:0] y1, logic inf1,
                             logic [W-1:0] x2, logic [W-1:0] y2, logic inf2);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {y2, x2, y1, x1};
    s_axis_tuser <= {inf2, inf1};
    sums_due = {sums_due, point_sum(x1, y1, inf1, x2, y2, inf2)};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain_results();
    while (sums_due.size() != 0) @(negedge clk);
    repeat (2000) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FIELD_PRIME) prime_q = 64'(val);
    else coeff_a_q = 64'(val);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    ec_sum_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[W-1:0], m_axis_tdata[2*W-1:W], m_axis_tuser[0], m_axis_tuser[1]};
      if (sums_due.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        fault_count++;
      end else begin
        want = sums_due.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected x=%h y=%h inf=%b bad=%b",
                   $time, want.x, want.y, want.inf, want.bad,
                   " actual x=%h y=%h inf=%b bad=%b",
                   got.x, got.y, got.inf, got.bad);
          fault_count++;
        end
      end
    end
  end

  always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL ec_prime_point_add_unit");
      $finish;
    end
  end

  // Fits b to one point, seeks y^2 = x^3+ax+b for a random x (small primes only).
  task automatic random_curve_pair(output logic [W-1:0] x1, output logic [W-1:0] y1,
                                   output logic [W-1:0] x2, output logic [W-1:0] y2);
    logic [63:0] p, b, px, qx, py, qy, ca, rhs, k;
    p = prime_q;
    ca = coeff_a_q % p;
    px = 64'($urandom_range(32'(p - 64'd1)));
    py = 64'($urandom_range(32'(p - 64'd1)));
    qx = 64'($urandom_range(32'(p - 64'd1)));
    b = fsub(fmul(py, py, p),
             fadd(fmul(fmul(px, px, p), px, p), fmul(ca, px, p), p), p);
    rhs = fadd(fadd(fmul(fmul(qx, qx, p), qx, p), fmul(ca, qx, p), p), b, p);
    qy = py;
    for (k = 64'd0; k < p; k++) begin
      if (fmul(k, k, p) == rhs) begin
        qy = k;
        break;
      end
    end
    x1 = W'(px); y1 = W'(py); x2 = W'(qx); y2 = W'(qy);
  endtask

  task automatic test_directed();
    logic [W-1:0] m;
    m = W'(prime_q);
    send_points(32'd0, 32'd0, 1'b1, 32'd0, 32'd0, 1'b1);
    send_points(32'd5, 32'd7, 1'b1, 32'd100, 32'd200, 1'b0);
    send_points(32'd5, 32'd7, 1'b0, 32'd100, 32'd200, 1'b1);
    send_points(32'd100, 32'd20, 1'b0, 32'd100, m - 32'd20, 1'b0);
    send_points(32'd100, 32'd0, 1'b0, 32'd100, 32'd0, 1'b0);
    send_points(32'd100, 32'd21, 1'b0, 32'd100, 32'd22, 1'b0);
    send_points(32'd100, 32'd21, 1'b0, 32'd100, 32'd21, 1'b0);
    send_points(32'd3, 32'd4, 1'b0, 32'd9, 32'd11, 1'b0);
    send_points(m - 32'd1, m - 32'd1, 1'b0, 32'd0, 32'd0, 1'b0);
    send_points('1, '1, 1'b0, '1, '1, 1'b0);
    send_points('1, 32'd0, 1'b0, 32'd0, '1, 1'b0);
    send_points(m, m + 32'd1, 1'b0, 32'd1, 32'd2, 1'b0);
    send_points(32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    send_points(32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
  endtask

  task automatic test_random(int count);
    logic [W-1:0] x1, y1, x2, y2;
    logic [63:0] p;
    int kind;
    p = prime_q;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(9);
      if (p >= 64'd3 && p < 64'd20000 && kind < 5) begin
        random_curve_pair(x1, y1, x2, y2);
        if (kind == 0) send_points(x1, y1, 1'b0, x1, y1, 1'b0);
        else if (kind == 1) send_points(x1, y1, 1'b0, x1, W'(fsub(64'd0, 64'(y1), p)), 1'b0);
        else send_points(x1, y1, 1'b0, x2, y2, 1'b0);
      end else if (kind < 8) begin
        x1 = $urandom_range(32'(p - 64'd1));
        y1 = $urandom_range(32'(p - 64'd1));
        x2 = $urandom_range(32'(p - 64'd1));
        y2 = $urandom_range(32'(p - 64'd1));
        send_points(x1, y1, 1'b0, x2, y2, 1'b0);
      end else begin
        send_points($urandom, $urandom, 1'($urandom_range(1)), $urandom, $urandom,
                    1'($urandom_range(1)));
      end
    end
  endtask

  task automatic run_phase(logic [W-1:0] prime, logic [W-1:0] coeff, int count);
    write_reg(CFG_FIELD_PRIME, prime);
    write_reg(CFG_CURVE_A, coeff);
    test_random(count);
    drain_results();
  endtask

  initial begin
    rst = 1'b1;
    clk = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_FIELD_PRIME;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    fault_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    prime_q = 64'd9181;
    coeff_a_q = 64'd1488;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_random(60);
    drain_results();
    send_idle_pct = 69;
    run_phase(32'd7919, 32'd0, 60);
    recv_stall_pct = 69;
    send_idle_pct = 0;
    run_phase(32'd3, 32'd2, 40);
    send_idle_pct = 28;
    recv_stall_pct = 28;
    run_phase(32'hFFFF_FFFB, 32'hFFFF_FFFA, 40);
    run_phase(32'd13, 32'hFFFF_FFFF, 50);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_phase(32'd91, 32'd5, 30);
    run_phase(32'd2, 32'd1, 10);
    run_phase(32'd1, 32'd0, 5);
    run_phase(32'd0, 32'd7, 5);
    run_phase(32'd65521, 32'd65520, 40);
    run_phase(32'd8191, 32'd3, 60);
    test_directed();
    drain_results();

    if (fault_count == 0) begin
      $display("PASS ec_prime_point_add_unit");
    end else begin
      $display("FAIL ec_prime_point_add_unit");
    end
    $finish;
  end

endmodule
